// File: hw/rtl/ppp_pkg.sv
// Shared types and constants for the perspective point projection core.
// No dependencies; every other file of the block imports this package.
package ppp_pkg;

  localparam int unsigned InW  = 16;  // input coordinate width
  localparam int unsigned CoW  = 32;  // coefficient width
  localparam int unsigned PrW  = 48;  // product width
  localparam int unsigned SumW = 51;  // row sum width at Q.28
  localparam int unsigned NumW = 56;  // numerator magnitude width (16 * sum)
  localparam int unsigned DenW = 51;  // denominator magnitude width
  localparam int unsigned QW   = 20;  // quotient and output width
  localparam int unsigned CfgW = 64;  // widest configuration register

  localparam logic signed [SumW-1:0] WOne = SumW'(1) << 28;
  localparam logic signed [QW-1:0] ProjMax = {1'b0, {(QW-1){1'b1}}};
  localparam logic signed [QW-1:0] ProjMin = {1'b1, {(QW-1){1'b0}}};

  typedef enum logic [2:0] {
    REG_ROW0_XY   = 3'd0,
    REG_ROW0_ZOFF = 3'd1,
    REG_ROW1_XY   = 3'd2,
    REG_ROW1_ZOFF = 3'd3,
    REG_ROW2_XY   = 3'd4,
    REG_ROW2_Z    = 3'd5
  } cfg_reg_e;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_ZERO = 2'd1,
    STAT_SAT  = 2'd2
  } status_e;

  // Data that travels down the divider chain for both coordinates.
  typedef struct packed {
    logic [NumW-1:0] rem_x;
    logic [NumW-1:0] rem_y;
    logic [DenW-1:0] den;
    logic [QW-1:0]   q_x;
    logic [QW-1:0]   q_y;
    logic            neg_x;
    logic            neg_y;
    logic            ovf_x;
    logic            ovf_y;
    logic            zero;
  } div_t;

endpackage

// File: hw/rtl/ppp_if.sv
// Handshake interfaces for the input and result items of the projection core.
// Depends on ppp_pkg for the field widths.
interface ppp_in_if;
  import ppp_pkg::*;
  logic                  valid;
  logic                  ready;
  logic signed [InW-1:0] world_x;
  logic signed [InW-1:0] world_y;
  logic signed [InW-1:0] world_z;
  modport source (output valid, world_x, world_y, world_z, input ready);
  modport sink   (input valid, world_x, world_y, world_z, output ready);
endinterface

interface ppp_out_if;
  import ppp_pkg::*;
  logic                 valid;
  logic                 ready;
  logic signed [QW-1:0] proj_x;
  logic signed [QW-1:0] proj_y;
  logic [1:0]           status;
  modport source (output valid, proj_x, proj_y, status, input ready);
  modport sink   (input valid, proj_x, proj_y, status, output ready);
endinterface

// File: hw/rtl/perspective_point_projection_core.sv
// Perspective point projection core: each accepted item passes the product, sum and preparation
// stages, the 20-cell divider chain and the output register. Throughput is one item per cycle while
// the pipeline advances, which it does whenever the output register is empty or its item is being taken.
// Reset (rst_ni, asynchronous, active low) clears all coefficients and every valid bit.
// Depends on ppp_pkg, ppp_if, ppp_row and ppp_div_cell.
module perspective_point_projection_core
  import ppp_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  ppp_in_if.sink           in_i,
  ppp_out_if.source        out_o,
  input  logic             cfg_we_i,
  input  logic [2:0]       cfg_idx_i,
  input  logic [CfgW-1:0]  cfg_wdata_i
);

  // Coefficient registers; the user must write them only while the pipeline is empty (not enforced here).
  logic [63:0] row0_xy_q, row0_zoff_q, row1_xy_q, row1_zoff_q, row2_xy_q;
  logic [31:0] row2_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row0_xy_q   <= '0;
      row0_zoff_q <= '0;
      row1_xy_q   <= '0;
      row1_zoff_q <= '0;
      row2_xy_q   <= '0;
      row2_z_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ROW0_XY:   row0_xy_q   <= cfg_wdata_i;
        REG_ROW0_ZOFF: row0_zoff_q <= cfg_wdata_i;
        REG_ROW1_XY:   row1_xy_q   <= cfg_wdata_i;
        REG_ROW1_ZOFF: row1_zoff_q <= cfg_wdata_i;
        REG_ROW2_XY:   row2_xy_q   <= cfg_wdata_i;
        REG_ROW2_Z:    row2_z_q    <= cfg_wdata_i[31:0];
        default: ;
      endcase
    end
  end

  // The whole pipeline moves as one: it holds only when a finished result is
  // waiting and the consumer is not taking it.
  logic adv, out_valid_q;
  assign adv      = !out_valid_q || out_o.ready;
  assign in_i.ready = adv;

  // The pixel offsets are Q16.16 and are moved up to Q.28 by a shift of 12.
  logic signed [SumW-1:0] off0, off1, u, v, w;
  assign off0 = SumW'($signed(row0_zoff_q[63:32])) <<< 12;
  assign off1 = SumW'($signed(row1_zoff_q[63:32])) <<< 12;

  ppp_row u_row0 (
    .clk_i, .en_i(adv), .x_i(in_i.world_x), .y_i(in_i.world_y), .z_i(in_i.world_z),
    .cx_i($signed(row0_xy_q[31:0])), .cy_i($signed(row0_xy_q[63:32])),
    .cz_i($signed(row0_zoff_q[31:0])), .off_i(off0), .sum_o(u)
  );
  ppp_row u_row1 (
    .clk_i, .en_i(adv), .x_i(in_i.world_x), .y_i(in_i.world_y), .z_i(in_i.world_z),
    .cx_i($signed(row1_xy_q[31:0])), .cy_i($signed(row1_xy_q[63:32])),
    .cz_i($signed(row1_zoff_q[31:0])), .off_i(off1), .sum_o(v)
  );
  ppp_row u_row2 (
    .clk_i, .en_i(adv), .x_i(in_i.world_x), .y_i(in_i.world_y), .z_i(in_i.world_z),
    .cx_i($signed(row2_xy_q[31:0])), .cy_i($signed(row2_xy_q[63:32])),
    .cz_i($signed(row2_z_q)), .off_i(WOne), .sum_o(w)
  );

  // Valid bits for the product and sum stages inside the row units and for the preparation stage.
  logic v_prod_q, v_sum_q, v_prep_q;

  // Preparation stage: numerators are scaled by 16 so the quotient lands in
  // Q16.4, and everything is turned into sign and magnitude. A quotient of
  // 2^20 or more is caught here, before the chain.
  logic signed [NumW-1:0] nx, ny;
  logic [NumW-1:0]        mx, my;
  logic [DenW-1:0]        mw;
  logic [NumW+QW-1:0]     dlim;
  div_t                   prep_d, prep_q;

  always_comb begin
    nx   = NumW'(u) <<< 4;
    ny   = NumW'(v) <<< 4;
    mx   = nx[NumW-1] ? NumW'(-nx) : NumW'(nx);
    my   = ny[NumW-1] ? NumW'(-ny) : NumW'(ny);
    mw   = w[SumW-1] ? DenW'(-w) : DenW'(w);
    dlim = (NumW+QW)'(mw) << QW;
    prep_d.rem_x = mx;
    prep_d.rem_y = my;
    prep_d.den   = mw;
    prep_d.q_x   = '0;
    prep_d.q_y   = '0;
    prep_d.neg_x = nx[NumW-1] ^ w[SumW-1];
    prep_d.neg_y = ny[NumW-1] ^ w[SumW-1];
    prep_d.ovf_x = (NumW+QW)'(mx) >= dlim;
    prep_d.ovf_y = (NumW+QW)'(my) >= dlim;
    prep_d.zero  = (w == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_prod_q <= 1'b0;
      v_sum_q  <= 1'b0;
      v_prep_q <= 1'b0;
    end else if (adv) begin
      v_prod_q <= in_i.valid;
      v_sum_q  <= v_prod_q;
      v_prep_q <= v_sum_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      prep_q <= prep_d;
    end
  end

  // Divider chain: one cell per quotient bit, most significant bit first.
  div_t chain_d [QW+1];
  logic chain_v [QW+1];
  assign chain_d[0] = prep_q;
  assign chain_v[0] = v_prep_q;

  for (genvar i = 0; i < QW; i++) begin : g_cell
    ppp_div_cell #(.Bit(QW - 1 - i)) u_cell (
      .clk_i, .rst_ni, .en_i(adv),
      .valid_i(chain_v[i]), .data_i(chain_d[i]),
      .valid_o(chain_v[i+1]), .data_o(chain_d[i+1])
    );
  end

  // Output stage: apply sign, clamp, and pick the status code. A negative
  // quotient may reach exactly 2^19; a positive one must stay below it.
  div_t                 fin;
  logic                 sat_x, sat_y;
  logic signed [QW-1:0] px_d, py_d, px_q, py_q;
  status_e              stat_d, stat_q;

  always_comb begin
    fin   = chain_d[QW];
    sat_x = fin.ovf_x || (fin.neg_x ? (fin.q_x[QW-1] && |fin.q_x[QW-2:0]) : fin.q_x[QW-1]);
    sat_y = fin.ovf_y || (fin.neg_y ? (fin.q_y[QW-1] && |fin.q_y[QW-2:0]) : fin.q_y[QW-1]);
    px_d  = sat_x ? (fin.neg_x ? ProjMin : ProjMax)
                  : (fin.neg_x ? QW'(-fin.q_x) : fin.q_x);
    py_d  = sat_y ? (fin.neg_y ? ProjMin : ProjMax)
                  : (fin.neg_y ? QW'(-fin.q_y) : fin.q_y);
    stat_d = (sat_x || sat_y) ? STAT_SAT : STAT_OK;
    if (fin.zero) begin
      px_d   = '0;
      py_d   = '0;
      stat_d = STAT_ZERO;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= chain_v[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      px_q   <= px_d;
      py_q   <= py_d;
      stat_q <= stat_d;
    end
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.proj_x = px_q;
  assign out_o.proj_y = py_q;
  assign out_o.status = stat_q;

endmodule

// File: hw/rtl/ppp_row.sv
// One matrix row: three products in one stage, their sum plus offset in the next.
// Depends on ppp_pkg.
module ppp_row
  import ppp_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic signed [InW-1:0]  x_i,
  input  logic signed [InW-1:0]  y_i,
  input  logic signed [InW-1:0]  z_i,
  input  logic signed [CoW-1:0]  cx_i,
  input  logic signed [CoW-1:0]  cy_i,
  input  logic signed [CoW-1:0]  cz_i,
  input  logic signed [SumW-1:0] off_i,
  output logic signed [SumW-1:0] sum_o
);

  logic signed [PrW-1:0]  px_q, py_q, pz_q;
  logic signed [SumW-1:0] off_q, sum_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      px_q  <= cx_i * x_i;
      py_q  <= cy_i * y_i;
      pz_q  <= cz_i * z_i;
      off_q <= off_i;
      sum_q <= SumW'(px_q) + SumW'(py_q) + SumW'(pz_q) + off_q;
    end
  end

  assign sum_o = sum_q;

endmodule

// File: hw/rtl/ppp_div_cell.sv
// One restoring-division cell: settles quotient bit Bit for both coordinates.
// Depends on ppp_pkg.
module ppp_div_cell
  import ppp_pkg::*;
#(
  parameter int unsigned Bit = 0
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic valid_i,
  input  div_t data_i,
  output logic valid_o,
  output div_t data_o
);

  localparam int unsigned WW = NumW + QW;

  logic [WW-1:0] dsh, rx, ry;
  div_t          data_d, data_q;
  logic          valid_q;

  always_comb begin
    dsh    = WW'(data_i.den) << Bit;
    rx     = WW'(data_i.rem_x);
    ry     = WW'(data_i.rem_y);
    data_d = data_i;
    if (rx >= dsh) begin
      data_d.rem_x = NumW'(rx - dsh);
      data_d.q_x   = data_i.q_x | (QW'(1) << Bit);
    end
    if (ry >= dsh) begin
      data_d.rem_y = NumW'(ry - dsh);
      data_d.q_y   = data_i.q_y | (QW'(1) << Bit);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// File: hw/rtl/ppp_checker.sv
// Port-level assertions for the projection core, bound to the top level.
// Depends on ppp_pkg and perspective_point_projection_core.
module ppp_checker
  import ppp_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_ready_i,
  input logic                 out_valid_i,
  input logic                 out_ready_i,
  input logic signed [QW-1:0] proj_x_i,
  input logic signed [QW-1:0] proj_y_i,
  input logic [1:0]           status_i
);

  // Input is held back only by a result that waits.
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> (out_valid_i && !out_ready_i))
    else $error("input stalled without a waiting result");

  // A zero denominator gives zero coordinates.
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && status_i == STAT_ZERO) |-> (proj_x_i == '0 && proj_y_i == '0))
    else $error("zero-denominator result with nonzero coordinates");

  // A stalled result keeps its valid.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload.
  a_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      ($stable(proj_x_i) && $stable(proj_y_i) && $stable(status_i)))
    else $error("result changed while stalled");

endmodule

bind perspective_point_projection_core ppp_checker u_ppp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .proj_x_i    (out_o.proj_x),
  .proj_y_i    (out_o.proj_y),
  .status_i    (out_o.status)
);

// File: sim/perspective_point_projection_core_tb.sv
// Self-checking testbench for perspective_point_projection_core.
// Depends on ppp_pkg, ppp_if and the core; predicts every pixel from its own matrix copy.
module perspective_point_projection_core_tb;
  import ppp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] IdxUnused6 = 3'd6;
  localparam logic [2:0] IdxUnused7 = 3'd7;
  localparam int unsigned DrainCycles = 40;      // well past the path of an item through the pipeline
  localparam int unsigned WatchdogLimit = 5000;

  typedef struct {
    logic signed [InW-1:0] x;
    logic signed [InW-1:0] y;
    logic signed [InW-1:0] z;
  } world_pt_t;

  typedef struct {
    logic signed [QW-1:0] px;
    logic signed [QW-1:0] py;
    status_e              status;
  } pixel_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_idx = '0;
  logic [CfgW-1:0] cfg_wdata = '0;

  ppp_in_if  pts_if ();
  ppp_out_if pix_if ();

  perspective_point_projection_core u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (pts_if),
    .out_o      (pix_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  // Our own copy of the eleven matrix coefficients, indexed as in the matrix.
  logic signed [CoW-1:0] coef [11];

  world_pt_t pending_points[$];
  pixel_t    expected_pixels[$];
  int unsigned mismatch_cnt = 0;
  bit idle_enable = 1'b1;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Projects one point: three exact row sums at Q.28, then truncating divides with saturation; w = 0 gives zero.
  function automatic pixel_t project_point(world_pt_t p);
    longint u, v, w, qx, qy;
    bit sat;
    pixel_t r;
    u = longint'(coef[0]) * p.x + longint'(coef[1]) * p.y + longint'(coef[2]) * p.z
        + longint'(coef[3]) * 4096;
    v = longint'(coef[4]) * p.x + longint'(coef[5]) * p.y + longint'(coef[6]) * p.z
        + longint'(coef[7]) * 4096;
    w = longint'(coef[8]) * p.x + longint'(coef[9]) * p.y + longint'(coef[10]) * p.z
        + (64'sd1 <<< 28);
    if (w == 0) begin
      r.px = '0;
      r.py = '0;
      r.status = STAT_ZERO;
      return r;
    end
    sat = 1'b0;
    qx = (u * 16) / w;
    qy = (v * 16) / w;
    if (qx > 524287) begin qx = 524287; sat = 1'b1; end
    if (qx < -524288) begin qx = -524288; sat = 1'b1; end
    if (qy > 524287) begin qy = 524287; sat = 1'b1; end
    if (qy < -524288) begin qy = -524288; sat = 1'b1; end
    r.px = qx[QW-1:0];
    r.py = qy[QW-1:0];
    r.status = sat ? STAT_SAT : STAT_OK;
    return r;
  endfunction

  // Sender: one item per handshake, with a random gap drawn after each item.
  int unsigned send_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    world_pt_t p;
    if (!rst_ni) begin
      pts_if.valid   <= 1'b0;
      pts_if.world_x <= '0;
      pts_if.world_y <= '0;
      pts_if.world_z <= '0;
      send_gap       <= 0;
    end else begin
      if (pts_if.valid && pts_if.ready) begin
        p.x = pts_if.world_x;
        p.y = pts_if.world_y;
        p.z = pts_if.world_z;
        expected_pixels.insert(expected_pixels.size(), project_point(p));
      end
      if (!pts_if.valid || pts_if.ready) begin
        if (send_gap != 0) begin
          send_gap     <= send_gap - 1;
          pts_if.valid <= 1'b0;
        end else if (pending_points.size() != 0) begin
          p = pending_points.pop_front();
          pts_if.world_x <= p.x;
          pts_if.world_y <= p.y;
          pts_if.world_z <= p.z;
          pts_if.valid   <= 1'b1;
          send_gap <= (idle_enable && $urandom_range(0, 1)) ? $urandom_range(0, 17) : 0;
        end else begin
          pts_if.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each accepted pixel against the oldest prediction.
  int unsigned recv_stall = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    pixel_t e;
    if (!rst_ni) begin
      pix_if.ready <= 1'b0;
      recv_stall   <= 0;
    end else begin
      if (pix_if.valid && pix_if.ready) begin
        if (expected_pixels.size() == 0) begin
          mismatch_cnt = mismatch_cnt + 1;
          if (mismatch_cnt <= 10)
            $display("%0t: pixel with no point pending: x=%0d y=%0d status=%0d", $realtime,
                     pix_if.proj_x, pix_if.proj_y, pix_if.status);
        end else begin
          e = expected_pixels.pop_front();
          if (pix_if.proj_x !== e.px || pix_if.proj_y !== e.py ||
              pix_if.status !== e.status) begin
            mismatch_cnt = mismatch_cnt + 1;
            if (mismatch_cnt <= 10)
              $display("%0t: pixel exp x=%0d y=%0d st=%0d got x=%0d y=%0d st=%0d", $realtime,
                       e.px, e.py, e.status, pix_if.proj_x, pix_if.proj_y, pix_if.status);
          end
        end
      end
      if (recv_stall != 0) begin
        recv_stall   <= recv_stall - 1;
        pix_if.ready <= 1'b0;
      end else begin
        pix_if.ready <= 1'b1;
        if (pix_if.valid && pix_if.ready && idle_enable && $urandom_range(0, 1))
          recv_stall <= $urandom_range(0, 17);
      end
    end
  end

  // Watchdog on cycles without any handshake.
  int unsigned quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((pts_if.valid && pts_if.ready) || (pix_if.valid && pix_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Register write; the core is idle, so the matrix copy is updated right away.
  task automatic write_reg(logic [2:0] idx, logic [CfgW-1:0] data);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    case (idx)
      REG_ROW0_XY:   begin coef[0] = data[31:0]; coef[1] = data[63:32]; end
      REG_ROW0_ZOFF: begin coef[2] = data[31:0]; coef[3] = data[63:32]; end
      REG_ROW1_XY:   begin coef[4] = data[31:0]; coef[5] = data[63:32]; end
      REG_ROW1_ZOFF: begin coef[6] = data[31:0]; coef[7] = data[63:32]; end
      REG_ROW2_XY:   begin coef[8] = data[31:0]; coef[9] = data[63:32]; end
      REG_ROW2_Z:    coef[10] = data[31:0];
      default: ;  // unused indexes are dropped by the core
    endcase
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic write_all(logic [CfgW-1:0] r0, logic [CfgW-1:0] r1, logic [CfgW-1:0] r2,
                           logic [CfgW-1:0] r3, logic [CfgW-1:0] r4, logic [CfgW-1:0] r5);
    write_reg(REG_ROW0_XY, r0);
    write_reg(REG_ROW0_ZOFF, r1);
    write_reg(REG_ROW1_XY, r2);
    write_reg(REG_ROW1_ZOFF, r3);
    write_reg(REG_ROW2_XY, r4);
    write_reg(REG_ROW2_Z, r5);
  endtask

  task automatic add_point(int x, int y, int z);
    world_pt_t p;
    p.x = x[15:0];
    p.y = y[15:0];
    p.z = z[15:0];
    pending_points.insert(pending_points.size(), p);
  endtask

  // Waits until every point has been sent and every pixel checked, then drains.
  task automatic wait_drained();
    while (pending_points.size() != 0 || pts_if.valid || expected_pixels.size() != 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // A coefficient of random magnitude: full-scale values mostly saturate, so the
  // shift spreads results across the ordinary, saturated and tiny ranges.
  function automatic logic [31:0] rand_coef(int unsigned min_shift);
    logic signed [31:0] c;
    c = $urandom;
    return c >>> $urandom_range(min_shift, 31);
  endfunction

  function automatic int rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 4) - 2;
      1: return $urandom_range(0, 2000) - 1000;
      default: return int'($signed(16'($urandom)));
    endcase
  endfunction

  initial begin
    logic [31:0] den_c;
    int unsigned n_items;
    foreach (coef[i]) coef[i] = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset matrix: w is exactly one and both numerators are zero.
    add_point(32767, -32768, 0);
    add_point(-1, 1, 32767);
    wait_drained();

    // Identity-like matrix with offsets; the row-2 x term cancels the constant one
    // at x = -1, which gives the zero denominator.
    write_all({32'h1000_0000, 32'h1000_0000}, {32'h0064_0000, 32'h0000_0000},
              {32'h0000_0000, 32'h1000_0000}, {32'hFF9C_0000, 32'hF000_0000},
              {32'h0000_0000, 32'h1000_0000}, 64'h0);
    // Writes to unused indexes and bits above the narrow register must change nothing.
    write_reg(IdxUnused6, '1);
    write_reg(IdxUnused7, 64'h1234_5678_9ABC_DEF0);
    write_reg(REG_ROW2_Z, 64'hFFFF_FFFF_0000_0000);
    add_point(-1, 5, 7);
    add_point(-1, -32768, 32767);
    add_point(0, 0, 0);
    add_point(1, 1, 1);
    add_point(32767, 32767, 32767);
    add_point(-32768, -32768, -32768);
    add_point(3, -3, 100);
    add_point(-2, 9, -9);
    wait_drained();

    // Saturation in both directions with a large gain.
    write_all({32'h7FFF_FFFF, 32'h7FFF_FFFF}, {32'h0000_0000, 32'h0000_0000},
              {32'h8000_0000, 32'h8000_0000}, {32'h0000_0000, 32'h0000_0000},
              64'h0, 64'h0);
    add_point(32767, 0, 0);
    add_point(-32768, 0, 0);
    add_point(0, 0, 0);
    add_point(1, -1, 0);
    wait_drained();

    // Register extremes: all ones, largest positive and most negative values.
    write_all('1, '1, '1, '1, '1, {32'h0, 32'hFFFF_FFFF});
    add_point(32767, 32767, 32767);
    add_point(1, 0, 0);
    add_point(-32768, 1, -1);
    wait_drained();
    write_all({2{32'h7FFF_FFFF}}, {2{32'h7FFF_FFFF}}, {2{32'h8000_0000}}, {2{32'h8000_0000}},
              {2{32'h7FFF_FFFF}}, {32'h0, 32'h8000_0000});
    add_point(32767, -32768, 32767);
    add_point(-1, -1, -1);
    add_point(0, 0, 1);
    wait_drained();

    // Random matrices; every phase waits for all pixels, so the sender also pauses.
    for (int ph = 0; ph < 12; ph++) begin
      idle_enable = (ph % 4) != 3;
      case ($urandom_range(0, 3))
        0: den_c = 32'h1000_0000;   // w vanishes at x = -1 when y and z terms are off
        1: den_c = 32'hF000_0000;   // w vanishes at x = 1
        default: den_c = rand_coef(8);
      endcase
      write_all({rand_coef(0), rand_coef(0)}, {rand_coef(0), rand_coef(0)},
                {rand_coef(0), rand_coef(0)}, {rand_coef(0), rand_coef(0)},
                {($urandom_range(0, 1) ? rand_coef(10) : 32'h0), den_c},
                {$urandom, ($urandom_range(0, 1) ? rand_coef(10) : 32'h0)});
      if ($urandom_range(0, 1)) write_reg(REG_ROW2_XY, {32'h0, den_c});
      if ($urandom_range(0, 1)) write_reg(REG_ROW2_Z, 64'h0);
      n_items = $urandom_range(40, 70);
      for (int i = 0; i < n_items; i++)
        add_point(rand_coord(), rand_coord(), rand_coord());
      wait_drained();
    end

    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
